// ----- rtl/hdg_pkg.sv -----
// Shared constants, types and the arctangent table for the compass heading block.
package hdg_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int ATAN_TABLE_LEN   = 24;
    localparam int IDX_W            = 5;

    localparam int SAMPLE_W = 12;
    localparam int CORR_W   = SAMPLE_W + 1;
    localparam int FRAC_W   = 16;
    localparam int VEC_W    = 32;
    localparam int ANG_W    = 32;
    localparam int HEAD_W   = 16;
    localparam int PROD_W   = ANG_W + HEAD_W;

    localparam logic [HEAD_W-1:0] FULL_TURN  = 16'd36000;
    localparam logic [ANG_W-1:0]  HALF_TURN  = 32'h8000_0000;
    localparam logic [PROD_W-1:0] ROUND_HALF = 48'h0000_8000_0000;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 1'b1;

    localparam logic [SAMPLE_W-1:0] OFFSET_X_RESET = 12'd57;
    localparam logic [SAMPLE_W-1:0] OFFSET_Y_RESET = 12'd61;

    typedef struct packed {
        logic             zero;
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
        logic [ANG_W-1:0] ang;
    } cordic_t;

    function automatic logic [ANG_W-1:0] atan_bam(input logic [IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2F9;
            5'd15:   val = 32'h0000_517C;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A2F;
            5'd19:   val = 32'h0000_0517;
            5'd20:   val = 32'h0000_028B;
            5'd21:   val = 32'h0000_0145;
            5'd22:   val = 32'h0000_00A2;
            5'd23:   val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/hdg_cordic_stage.sv -----
// One registered vectoring micro-rotation of the heading pipeline.
module hdg_cordic_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [hdg_pkg::IDX_W-1:0]         idx,
    input  logic                              stage_valid_in,
    input  hdg_pkg::cordic_t                  stage_in,
    output logic                              stage_valid_out,
    output hdg_pkg::cordic_t                  stage_out
);

    logic signed [hdg_pkg::VEC_W-1:0] x_in;
    logic signed [hdg_pkg::VEC_W-1:0] y_in;
    logic signed [hdg_pkg::VEC_W-1:0] xs;
    logic signed [hdg_pkg::VEC_W-1:0] ys;
    logic [hdg_pkg::ANG_W-1:0]        atan_val;
    hdg_pkg::cordic_t                 stage_next;
    hdg_pkg::cordic_t                 stage_reg;
    logic                             valid_reg;

    assign x_in     = $signed(stage_in.x);
    assign y_in     = $signed(stage_in.y);
    assign xs       = x_in >>> idx;
    assign ys       = y_in >>> idx;
    assign atan_val = hdg_pkg::atan_bam(idx);

    // turn clockwise while the residual is zero or positive
    always_comb
    begin
        stage_next = stage_in;
        if (!y_in[hdg_pkg::VEC_W-1])
        begin
            stage_next.x   = x_in + ys;
            stage_next.y   = y_in - xs;
            stage_next.ang = stage_in.ang + atan_val;
        end
        else
        begin
            stage_next.x   = x_in - ys;
            stage_next.y   = y_in + xs;
            stage_next.ang = stage_in.ang - atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid_out = valid_reg;
    assign stage_out       = stage_reg;

endmodule

// ----- rtl/compass_heading_from_magnetometer_top.sv -----
// Top level of the compass heading block: offset removal, CORDIC pipeline, scaling.
//
// Input channel: in_valid/in_ready carry one raw sample (sample_x, sample_y).
// Output channel: out_valid/out_ready carry heading_centideg, the angle of the
// offset-corrected vector in hundredths of a degree, 0 along +X, 0..35999.
// Configuration: cfg_we writes cfg_data into offset_x (index 0) or
// offset_y (index 1) at the clock edge; write only while the block is idle.
// Pipeline: a register after offset removal and half-plane fold, one register
// per CORDIC micro-rotation, one after the 32x16 scaling multiply, and the
// output register after rounding and wrap.
// Throughput: one item per cycle unless the receiver stalls; every stage holds one item.
// Reset: all valid bits clear, offsets return to 57 and 61.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// A zero corrected vector gives a heading of 0.
module compass_heading_from_magnetometer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hdg_pkg::SAMPLE_W-1:0] sample_x,
    input  logic signed [hdg_pkg::SAMPLE_W-1:0] sample_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hdg_pkg::HEAD_W-1:0]          heading_centideg,
    input  logic                                cfg_we,
    input  logic [hdg_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [hdg_pkg::SAMPLE_W-1:0]        cfg_data
);

    localparam int N = hdg_pkg::ANGLE_ITERATIONS;

    logic [hdg_pkg::SAMPLE_W-1:0] offset_x_reg;
    logic [hdg_pkg::SAMPLE_W-1:0] offset_y_reg;

    logic                         en;
    logic signed [hdg_pkg::CORR_W-1:0] cx;
    logic signed [hdg_pkg::CORR_W-1:0] cy;
    logic signed [hdg_pkg::VEC_W-1:0]  vx;
    logic signed [hdg_pkg::VEC_W-1:0]  vy;
    hdg_pkg::cordic_t             s0_next;
    hdg_pkg::cordic_t             s0_reg;
    logic                         s0_valid_reg;

    logic                         stage_valid [0:N];
    hdg_pkg::cordic_t             stage_data  [0:N];
    logic [N:0]                   valid_vec;

    logic [hdg_pkg::PROD_W-1:0]   mult_next;
    logic [hdg_pkg::PROD_W-1:0]   mult_reg;
    logic                         mult_zero_reg;
    logic                         mult_valid_reg;

    logic [hdg_pkg::PROD_W-1:0]   rounded;
    logic [hdg_pkg::HEAD_W-1:0]   head_raw;
    logic [hdg_pkg::HEAD_W-1:0]   head_next;
    logic [hdg_pkg::HEAD_W-1:0]   head_reg;
    logic                         out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= hdg_pkg::OFFSET_X_RESET;
            offset_y_reg <= hdg_pkg::OFFSET_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hdg_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data;
                hdg_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // remove offsets, fold the left half plane by a half turn
    assign cx = hdg_pkg::CORR_W'(sample_x) - hdg_pkg::CORR_W'($signed(offset_x_reg));
    assign cy = hdg_pkg::CORR_W'(sample_y) - hdg_pkg::CORR_W'($signed(offset_y_reg));
    assign vx = {{(hdg_pkg::VEC_W - hdg_pkg::CORR_W - hdg_pkg::FRAC_W){cx[hdg_pkg::CORR_W-1]}},
                 cx, {hdg_pkg::FRAC_W{1'b0}}};
    assign vy = {{(hdg_pkg::VEC_W - hdg_pkg::CORR_W - hdg_pkg::FRAC_W){cy[hdg_pkg::CORR_W-1]}},
                 cy, {hdg_pkg::FRAC_W{1'b0}}};

    always_comb
    begin
        s0_next.zero = (cx == '0) && (cy == '0);
        if (cx[hdg_pkg::CORR_W-1])
        begin
            s0_next.x   = -vx;
            s0_next.y   = -vy;
            s0_next.ang = hdg_pkg::HALF_TURN;
        end
        else
        begin
            s0_next.x   = vx;
            s0_next.y   = vy;
            s0_next.ang = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= s0_next;
        end
    end

    assign stage_valid[0] = s0_valid_reg;
    assign stage_data[0]  = s0_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_iter
        hdg_cordic_stage u_stage (
            .clk             (clk),
            .rst_n           (rst_n),
            .en              (en),
            .idx             (hdg_pkg::IDX_W'(k)),
            .stage_valid_in  (stage_valid[k]),
            .stage_in        (stage_data[k]),
            .stage_valid_out (stage_valid[k+1]),
            .stage_out       (stage_data[k+1])
        );
    end

    for (genvar k = 0; k <= N; k++)
    begin : g_vvec
        assign valid_vec[k] = stage_valid[k];
    end

    // scale the binary angle to hundredths of a degree
    assign mult_next = hdg_pkg::PROD_W'(stage_data[N].ang) * hdg_pkg::PROD_W'(hdg_pkg::FULL_TURN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mult_valid_reg <= stage_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mult_reg      <= mult_next;
            mult_zero_reg <= stage_data[N].zero;
        end
    end

    // round to nearest, wrap a full turn to zero
    assign rounded  = mult_reg + hdg_pkg::ROUND_HALF;
    assign head_raw = rounded[hdg_pkg::PROD_W-1:hdg_pkg::ANG_W];

    always_comb
    begin
        if (mult_zero_reg)
        begin
            head_next = '0;
        end
        else if (head_raw >= hdg_pkg::FULL_TURN)
        begin
            head_next = head_raw - hdg_pkg::FULL_TURN;
        end
        else
        begin
            head_next = head_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= mult_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign heading_centideg = head_reg;

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_centideg < hdg_pkg::FULL_TURN))
        else $error("heading out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(valid_vec) && $stable(mult_valid_reg)))
        else $error("pipeline moved during stall");

    a_zero_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (en && mult_valid_reg && mult_zero_reg) |=> (heading_centideg == '0))
        else $error("zero vector gave nonzero heading");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s0_valid_reg)
        else $error("accepted item not in first stage");

    a_last_to_mult: assert property (@(posedge clk) disable iff (!rst_n)
        (en && stage_valid[N]) |=> mult_valid_reg)
        else $error("item lost before scaling stage");

endmodule
